### sv/cpst_pkg.sv
// Shared types, constants and the hash function of the call profiler.
// Used by cpst_seq and call_profiler_self_total_core; depends on nothing.
`timescale 1ns / 1ps

package cpst_pkg;

	localparam int TABLE_ENTRIES = 512;
	localparam int STACK_DEPTH   = 256;
	localparam int HASH_MODULUS  = 511;
	localparam int SLOT_AW       = $clog2(TABLE_ENTRIES);
	localparam int FRAME_AW      = $clog2(STACK_DEPTH);
	localparam int LEVEL_W       = $clog2(STACK_DEPTH + 1);
	localparam int TIME_W        = 48;
	localparam int OPS_W         = 32;
	localparam int ADDR_W        = 32;
	localparam int CNT_W         = 32;
	localparam int DEPTH_W       = 9;
	localparam int PADDR_W       = 3;
	localparam int PDATA_W       = 32;

	localparam logic [1:0] REQ_CALL  = 2'd0;
	localparam logic [1:0] REQ_RET   = 2'd1;
	localparam logic [1:0] REQ_FLUSH = 2'd2;
	localparam logic [1:0] REQ_READ  = 2'd3;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_TABLE_FULL  = 3'd1;
	localparam logic [2:0] ST_STACK_OVF   = 3'd2;
	localparam logic [2:0] ST_STACK_UNDER = 3'd3;
	localparam logic [2:0] ST_DEPTH_UNDER = 3'd4;

	localparam logic REG_PROFILE_ENABLE = 1'b0;

	typedef struct packed {
		logic               used;
		logic [ADDR_W-1:0]  addr;
		logic [CNT_W-1:0]   calls;
		logic [CNT_W-1:0]   accel_calls;
		logic [DEPTH_W-1:0] depth;
		logic [TIME_W-1:0]  start_time;
		logic [OPS_W-1:0]   start_ops;
		logic [TIME_W-1:0]  incl_time;
		logic [OPS_W-1:0]   incl_ops;
		logic [TIME_W-1:0]  excl_time;
		logic [OPS_W-1:0]   excl_ops;
	} slot_rec_t;

	typedef struct packed {
		logic [SLOT_AW-1:0] slot;
		logic [TIME_W-1:0]  enter_time;
		logic [OPS_W-1:0]   entry_ops;
		logic [TIME_W-1:0]  child_time;
		logic [OPS_W-1:0]   child_ops;
	} frame_rec_t;

	typedef struct packed {
		logic               we;
		logic [SLOT_AW-1:0] addr;
		slot_rec_t          wdata;
	} slot_port_t;

	typedef struct packed {
		logic                we;
		logic [FRAME_AW-1:0] addr;
		frame_rec_t          wdata;
	} frame_port_t;

	typedef struct packed {
		logic [2:0]        status;
		logic              entry_valid;
		logic [ADDR_W-1:0] entry_addr;
		logic [CNT_W-1:0]  calls;
		logic [CNT_W-1:0]  accel_calls;
		logic [OPS_W-1:0]  inclusive_ops;
		logic [TIME_W-1:0] inclusive_time;
		logic [OPS_W-1:0]  exclusive_ops;
		logic [TIME_W-1:0] exclusive_time;
	} result_t;

	// Start slot of the probe: addr mod 511. Since 2^9 is 1 mod 511, the
	// 9-bit digits are summed, folded once more, and one subtract finishes.
	function automatic logic [SLOT_AW-1:0] hash_pos(input logic [ADDR_W-1:0] a);
		logic [10:0] s;
		logic [9:0]  t;
		s = 11'(a[8:0]) + 11'(a[17:9]) + 11'(a[26:18]) + 11'(a[31:27]);
		t = 10'(s[8:0]) + 10'(s[10:9]);
		if (t >= 10'(HASH_MODULUS)) begin
			t = t - 10'(HASH_MODULUS);
		end
		return t[SLOT_AW-1:0];
	endfunction

endpackage

### sv/call_profiler_self_total_core.sv
// Top level of the call profiler: register port, slot and frame memories,
// sequencer and result register. Depends on cpst_pkg, cpst_ram, cpst_seq.
`timescale 1ns / 1ps

// The profiler takes one transaction at a time: a call, a return, a flush
// of all frames or a read of one table slot, and answers each with exactly
// one result transaction. After reset a clearing pass marks every table
// slot free; in_stall stays high meanwhile, while register writes are
// taken as always. A call probes slots linearly from func_addr mod 511,
// with one read of the slot memory and one compare per probe. A flush pops
// frames one at a time; a return or a flush on an empty stack pops none.
// The sequence is set by the single port of the slot memory, which is read
// for every probe and pop and written back on a hit and on a pop, and
// by the frame memory, which must yield both the top frame and its parent.
// A finished result waits in the output register, and the next transaction
// is accepted meanwhile. profile_enable at byte address 0 gates calls,
// returns and flushes.

module call_profiler_self_total_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cpst_pkg::PADDR_W-1:0]  paddr,
	input  logic [cpst_pkg::PDATA_W-1:0]  pwdata,
	output logic [cpst_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    req_type,
	input  logic [cpst_pkg::ADDR_W-1:0]   func_addr,
	input  logic                          accel_call,
	input  logic [cpst_pkg::TIME_W-1:0]   time_now,
	input  logic [cpst_pkg::OPS_W-1:0]    ops_now,
	input  logic [cpst_pkg::SLOT_AW-1:0]  slot_index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    status,
	output logic                          entry_valid,
	output logic [cpst_pkg::ADDR_W-1:0]   entry_addr,
	output logic [cpst_pkg::CNT_W-1:0]    calls,
	output logic [cpst_pkg::CNT_W-1:0]    accel_calls,
	output logic [cpst_pkg::OPS_W-1:0]    inclusive_ops,
	output logic [cpst_pkg::TIME_W-1:0]   inclusive_time,
	output logic [cpst_pkg::OPS_W-1:0]    exclusive_ops,
	output logic [cpst_pkg::TIME_W-1:0]   exclusive_time
);

	logic                  enable_q;
	logic                  out_valid_q;
	cpst_pkg::result_t     out_q;
	cpst_pkg::slot_port_t  slot_port;
	cpst_pkg::slot_rec_t   slot_rdata;
	cpst_pkg::frame_port_t frame_port;
	cpst_pkg::frame_rec_t  frame_rdata;
	logic                  res_valid;
	cpst_pkg::result_t     res;
	logic                  out_free;

	// Register port: always ready, one enable bit.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == cpst_pkg::REG_PROFILE_ENABLE) ?
		cpst_pkg::PDATA_W'(enable_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (psel && penable && pwrite &&
			(paddr[2] == cpst_pkg::REG_PROFILE_ENABLE)) begin
			enable_q <= pwdata[0];
		end
	end

	cpst_ram #(
		.WIDTH ($bits(cpst_pkg::slot_rec_t)),
		.DEPTH (cpst_pkg::TABLE_ENTRIES)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_port.we),
		.addr  (slot_port.addr),
		.wdata (slot_port.wdata),
		.rdata (slot_rdata)
	);

	cpst_ram #(
		.WIDTH ($bits(cpst_pkg::frame_rec_t)),
		.DEPTH (cpst_pkg::STACK_DEPTH)
	) u_frame_ram (
		.clk   (clk),
		.we    (frame_port.we),
		.addr  (frame_port.addr),
		.wdata (frame_port.wdata),
		.rdata (frame_rdata)
	);

	cpst_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.enable      (enable_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.func_addr   (func_addr),
		.accel_call  (accel_call),
		.time_now    (time_now),
		.ops_now     (ops_now),
		.slot_index  (slot_index),
		.slot_port   (slot_port),
		.slot_rdata  (slot_rdata),
		.frame_port  (frame_port),
		.frame_rdata (frame_rdata),
		.res_valid   (res_valid),
		.res         (res),
		.res_take    (out_free)
	);

	// The output register frees up in the same cycle that its transaction
	// completes, so a new result can follow without a gap.
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_q.status;
	assign entry_valid    = out_q.entry_valid;
	assign entry_addr     = out_q.entry_addr;
	assign calls          = out_q.calls;
	assign accel_calls    = out_q.accel_calls;
	assign inclusive_ops  = out_q.inclusive_ops;
	assign inclusive_time = out_q.inclusive_time;
	assign exclusive_ops  = out_q.exclusive_ops;
	assign exclusive_time = out_q.exclusive_time;

endmodule

### sv/cpst_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module cpst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

### sv/cpst_seq.sv
// Sequencer of the call profiler: probe, push, pop and read over the
// slot and frame memories. Depends on cpst_pkg.
`timescale 1ns / 1ps

module cpst_seq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      enable,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                req_type,
	input  logic [cpst_pkg::ADDR_W-1:0] func_addr,
	input  logic                      accel_call,
	input  logic [cpst_pkg::TIME_W-1:0] time_now,
	input  logic [cpst_pkg::OPS_W-1:0]  ops_now,
	input  logic [cpst_pkg::SLOT_AW-1:0] slot_index,
	output cpst_pkg::slot_port_t      slot_port,
	input  cpst_pkg::slot_rec_t       slot_rdata,
	output cpst_pkg::frame_port_t     frame_port,
	input  cpst_pkg::frame_rec_t      frame_rdata,
	output logic                      res_valid,
	output cpst_pkg::result_t         res,
	input  logic                      res_take
);

	typedef enum logic [9:0] {
		S_CLEAR = 10'b0000000001,
		S_IDLE  = 10'b0000000010,
		S_PROBE = 10'b0000000100,
		S_PCHK  = 10'b0000001000,
		S_POPF  = 10'b0000010000,
		S_POPS  = 10'b0000100000,
		S_POPU  = 10'b0001000000,
		S_RDRQ  = 10'b0010000000,
		S_RDAT  = 10'b0100000000,
		S_RESP  = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	logic [cpst_pkg::LEVEL_W-1:0] level_q, level_d;
	logic [cpst_pkg::SLOT_AW-1:0] pos_q, pos_d, cnt_q, cnt_d, clr_q, clr_d;

	logic [1:0]                    req_q;
	logic [cpst_pkg::ADDR_W-1:0]   addr_q;
	logic                          accel_q;
	logic [cpst_pkg::TIME_W-1:0]   now_q;
	logic [cpst_pkg::OPS_W-1:0]    ops_q;
	logic [cpst_pkg::SLOT_AW-1:0]  idx_q;
	cpst_pkg::frame_rec_t          fr_q;
	logic [cpst_pkg::TIME_W-1:0]   run_q;
	logic [cpst_pkg::OPS_W-1:0]    runops_q;
	cpst_pkg::result_t             res_q, res_d;

	logic                          accept;
	logic                          hit;
	cpst_pkg::slot_rec_t           base, upd;
	cpst_pkg::frame_rec_t          parent;
	logic [cpst_pkg::LEVEL_W-1:0]  top;
	logic [cpst_pkg::LEVEL_W-1:0]  below;

	assign accept    = in_valid && (state_q == S_IDLE);
	assign in_stall  = (state_q != S_IDLE);
	assign res_valid = (state_q == S_RESP);
	assign res       = res_q;
	assign top       = level_q - cpst_pkg::LEVEL_W'(1);
	assign below     = level_q - cpst_pkg::LEVEL_W'(2);

	always_comb begin
		base = slot_rdata;
		if (!slot_rdata.used) begin
			base      = '0;
			base.used = 1'b1;
			base.addr = addr_q;
		end
		hit = !slot_rdata.used || (slot_rdata.addr == addr_q);
	end

	always_comb begin
		state_d    = state_q;
		level_d    = level_q;
		pos_d      = pos_q;
		cnt_d      = cnt_q;
		clr_d      = clr_q;
		res_d      = res_q;
		upd        = base;
		parent     = frame_rdata;
		slot_port  = '0;
		frame_port = '0;
		slot_port.addr  = pos_q;
		frame_port.addr = top[cpst_pkg::FRAME_AW-1:0];
		unique case (state_q)
			S_CLEAR: begin
				slot_port.we   = 1'b1;
				slot_port.addr = clr_q;
				clr_d = clr_q + cpst_pkg::SLOT_AW'(1);
				if (clr_q == cpst_pkg::SLOT_AW'(cpst_pkg::TABLE_ENTRIES - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					res_d = '0;
					if (req_type == cpst_pkg::REQ_READ) begin
						state_d = S_RDRQ;
					end else if (!enable) begin
						state_d = S_RESP;
					end else if (req_type == cpst_pkg::REQ_CALL) begin
						pos_d   = cpst_pkg::hash_pos(func_addr);
						cnt_d   = '0;
						state_d = S_PROBE;
					end else begin
						state_d = S_POPF;
					end
				end
			end
			S_PROBE: begin
				state_d = S_PCHK;
			end
			S_PCHK: begin
				if (hit) begin
					if (level_q == cpst_pkg::LEVEL_W'(cpst_pkg::STACK_DEPTH)) begin
						res_d.status = cpst_pkg::ST_STACK_OVF;
					end else begin
						upd.calls       = base.calls + cpst_pkg::CNT_W'(1);
						upd.accel_calls = base.accel_calls + cpst_pkg::CNT_W'(accel_q);
						if (base.depth == '0) begin
							upd.start_time = now_q;
							upd.start_ops  = ops_q;
						end
						upd.depth       = base.depth + cpst_pkg::DEPTH_W'(1);
						slot_port.we    = 1'b1;
						slot_port.wdata = upd;
						frame_port.we   = 1'b1;
						frame_port.addr = level_q[cpst_pkg::FRAME_AW-1:0];
						frame_port.wdata.slot       = pos_q;
						frame_port.wdata.enter_time = now_q;
						frame_port.wdata.entry_ops  = ops_q;
						level_d = level_q + cpst_pkg::LEVEL_W'(1);
						res_d.status = cpst_pkg::ST_OK;
					end
					state_d = S_RESP;
				end else if (cnt_q == cpst_pkg::SLOT_AW'(cpst_pkg::TABLE_ENTRIES - 1)) begin
					res_d.status = cpst_pkg::ST_TABLE_FULL;
					state_d = S_RESP;
				end else begin
					pos_d   = pos_q + cpst_pkg::SLOT_AW'(1);
					cnt_d   = cnt_q + cpst_pkg::SLOT_AW'(1);
					state_d = S_PROBE;
				end
			end
			S_POPF: begin
				if (level_q == '0) begin
					res_d.status = (req_q == cpst_pkg::REQ_RET) ?
						cpst_pkg::ST_STACK_UNDER : cpst_pkg::ST_OK;
					state_d = S_RESP;
				end else begin
					state_d = S_POPS;
				end
			end
			S_POPS: begin
				slot_port.addr  = frame_rdata.slot;
				frame_port.addr = below[cpst_pkg::FRAME_AW-1:0];
				state_d = S_POPU;
			end
			S_POPU: begin
				if (slot_rdata.depth == '0) begin
					res_d.status = cpst_pkg::ST_DEPTH_UNDER;
					state_d = S_RESP;
				end else begin
					upd = slot_rdata;
					upd.excl_time = slot_rdata.excl_time + run_q - fr_q.child_time;
					upd.excl_ops  = slot_rdata.excl_ops + runops_q - fr_q.child_ops;
					upd.depth     = slot_rdata.depth - cpst_pkg::DEPTH_W'(1);
					if (slot_rdata.depth == cpst_pkg::DEPTH_W'(1)) begin
						upd.incl_time = slot_rdata.incl_time + (now_q - slot_rdata.start_time);
						upd.incl_ops  = slot_rdata.incl_ops + (ops_q - slot_rdata.start_ops);
						upd.start_time = '0;
						upd.start_ops  = '0;
					end
					slot_port.we    = 1'b1;
					slot_port.addr  = fr_q.slot;
					slot_port.wdata = upd;
					parent.child_time = frame_rdata.child_time + run_q;
					parent.child_ops  = frame_rdata.child_ops + runops_q;
					frame_port.we     = (top != '0);
					frame_port.addr   = below[cpst_pkg::FRAME_AW-1:0];
					frame_port.wdata  = parent;
					level_d = top;
					if ((req_q == cpst_pkg::REQ_FLUSH) && (top != '0)) begin
						state_d = S_POPF;
					end else begin
						res_d.status = cpst_pkg::ST_OK;
						state_d = S_RESP;
					end
				end
			end
			S_RDRQ: begin
				slot_port.addr = idx_q;
				state_d = S_RDAT;
			end
			S_RDAT: begin
				if (slot_rdata.used) begin
					res_d.entry_valid    = 1'b1;
					res_d.entry_addr     = slot_rdata.addr;
					res_d.calls          = slot_rdata.calls;
					res_d.accel_calls    = slot_rdata.accel_calls;
					res_d.inclusive_ops  = slot_rdata.incl_ops;
					res_d.inclusive_time = slot_rdata.incl_time;
					res_d.exclusive_ops  = slot_rdata.excl_ops;
					res_d.exclusive_time = slot_rdata.excl_time;
				end
				state_d = S_RESP;
			end
			S_RESP: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			level_q <= '0;
			pos_q   <= '0;
			cnt_q   <= '0;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			level_q <= level_d;
			pos_q   <= pos_d;
			cnt_q   <= cnt_d;
			clr_q   <= clr_d;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (accept) begin
			req_q   <= req_type;
			addr_q  <= func_addr;
			accel_q <= accel_call;
			now_q   <= time_now;
			ops_q   <= ops_now;
			idx_q   <= slot_index;
		end
		if (state_q == S_POPS) begin
			fr_q     <= frame_rdata;
			run_q    <= now_q - frame_rdata.enter_time;
			runops_q <= ops_q - frame_rdata.entry_ops;
		end
	end

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= cpst_pkg::LEVEL_W'(cpst_pkg::STACK_DEPTH))
		else $error("frame stack level beyond its depth");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !slot_port.we && !frame_port.we)
		else $error("memory write while idle");

	a_frame_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		frame_port.we |-> (state_q == S_PCHK || state_q == S_POPU))
		else $error("frame write outside push or pop");

	a_resp_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && res_take) |=> (state_q == S_IDLE))
		else $error("result taken but sequencer not idle");

endmodule
